// ----- hw/rtl/ftsve_pkg.sv -----
// shared types, constants and codes for the frequency table snap and vote encoder
// no dependencies; imported by every module of the block

package ftsve_pkg;

    localparam int TABLE_DEPTH_DEF  = 16;
    localparam int FREQ_W           = 32;
    localparam int INDEX_W          = 4;
    localparam int CNT_W            = 5;
    localparam int SHIFT_W          = 4;
    localparam int WIDTH_W          = 5;
    localparam int ENABLE_W         = 16;
    localparam int VOTE_VALUE_SHIFT = 4;
    localparam int ENABLE_POS       = 16;
    localparam int APB_ADDR_W       = 4;
    localparam int APB_DATA_W       = 32;

    // register indexes on the config port
    localparam logic [1:0] REG_ENTRY_COUNT  = 2'd0;
    localparam logic [1:0] REG_VOTE_SHIFT   = 2'd1;
    localparam logic [1:0] REG_VOTE_WIDTH   = 2'd2;
    localparam logic [1:0] REG_VOTE_ENABLE  = 2'd3;

    // reset values
    localparam logic [CNT_W-1:0]    RST_ENTRY_COUNT = 5'd1;
    localparam logic [SHIFT_W-1:0]  RST_VOTE_SHIFT  = 4'd0;
    localparam logic [WIDTH_W-1:0]  RST_VOTE_WIDTH  = 5'd16;
    localparam logic [ENABLE_W-1:0] RST_VOTE_ENABLE = 16'd0;

    // input word command codes
    localparam logic CMD_LOAD    = 1'b0;
    localparam logic CMD_REQUEST = 1'b1;

    typedef struct packed {
        logic [CNT_W-1:0]    entry_count;
        logic [SHIFT_W-1:0]  vote_shift;
        logic [WIDTH_W-1:0]  vote_width;
        logic [ENABLE_W-1:0] vote_enable_bits;
    } ftsve_cfg_t;

    typedef struct packed {
        logic load_en;     // write table slot from the input word
        logic req_start;   // latch request frequency and mode
        logic rd_en;       // table read this cycle
        logic rd_first;    // read is the first of the scan (last slot in use)
        logic rd_last;     // read is slot 0, last of the scan
        logic choose;      // resolve snapped frequency
        logic encode;      // build vote and load output register
    } ftsve_cmd_t;

    typedef struct packed {
        logic out_busy;    // output register holds a word not taken this cycle
    } ftsve_status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_CHOOSE,
        ST_ENCODE
    } ftsve_state_t;

endpackage

// ----- hw/rtl/ftsve_if.sv -----
// valid/ready channel interfaces for input words and result words
// depends on ftsve_pkg for field widths

interface ftsve_in_if;
    import ftsve_pkg::*;

    logic                 valid;
    logic                 ready;
    logic                 command;
    logic [INDEX_W-1:0]   entry_index;
    logic [FREQ_W-1:0]    entry_freq;
    logic [FREQ_W-1:0]    request_freq;
    logic                 round_down;

    modport source (
        output valid, command, entry_index, entry_freq, request_freq, round_down,
        input  ready
    );
    modport sink (
        input  valid, command, entry_index, entry_freq, request_freq, round_down,
        output ready
    );
endinterface

interface ftsve_out_if;
    import ftsve_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [FREQ_W-1:0]    chosen_freq;
    logic                 vote_write;
    logic [FREQ_W-1:0]    vote_word;

    modport source (
        output valid, chosen_freq, vote_write, vote_word,
        input  ready
    );
    modport sink (
        input  valid, chosen_freq, vote_write, vote_word,
        output ready
    );
endinterface

// ----- hw/rtl/freq_table_snap_and_vote_encode.sv -----
// top level of the frequency table snap and vote encoder
// depends on ftsve_pkg, ftsve_if, ftsve_cfg, ftsve_ctrl and ftsve_dp

// Load words (command 0) write one slot of the frequency table and are taken
// one per cycle while no request is in progress; they produce no result. A
// request word (command 1) scans the slots in use, one table entry per cycle
// through the single read port of the table memory, and snaps the request:
// round_down picks the larger of slot 0 and the largest entry at or below the
// request, otherwise the smaller of the last slot in use and the smallest
// entry at or above it. Each request yields one result word; vote_write is
// set and vote_word carries the encoded vote when the snapped frequency
// differs from the last one chosen, which is then remembered. After a
// request is accepted the block reads the n slots in use, n being the
// clamped entry count, takes in the last entry, picks the result, then
// encodes and loads the output register; the input is ready again after
// that. A result waiting in the output register does not stop loads or the
// scan of the next request; only the encode of the next request waits until
// the waiting word is taken. Table slots come out of reset undefined and must
// be loaded before a request reads them.

module freq_table_snap_and_vote_encode #(
    parameter int TABLE_DEPTH = ftsve_pkg::TABLE_DEPTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    ftsve_in_if.sink                          items,
    ftsve_out_if.source                       results,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [ftsve_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [ftsve_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [ftsve_pkg::APB_DATA_W-1:0]  prdata,
    output logic                              pready
);
    import ftsve_pkg::*;

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    ftsve_cfg_t    cfg;
    ftsve_cmd_t    cmd;
    ftsve_status_t status;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] scan_last;

    // register file
    ftsve_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // sequencer for loads, scan and encode
    ftsve_ctrl #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (items.valid),
        .in_command (items.command),
        .in_ready   (items.ready),
        .scan_last  (scan_last),
        .status     (status),
        .cmd        (cmd),
        .rd_addr    (rd_addr)
    );

    // table, compare unit, encoder and output register
    ftsve_dp #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .cmd          (cmd),
        .rd_addr      (rd_addr),
        .scan_last    (scan_last),
        .status       (status),
        .entry_index  (items.entry_index),
        .entry_freq   (items.entry_freq),
        .request_freq (items.request_freq),
        .round_down   (items.round_down),
        .out_valid    (results.valid),
        .out_ready    (results.ready),
        .chosen_freq  (results.chosen_freq),
        .vote_write   (results.vote_write),
        .vote_word    (results.vote_word)
    );

endmodule

// ----- hw/rtl/ftsve_cfg.sv -----
// apb-style configuration register file
// depends on ftsve_pkg for register indexes, reset values and the config struct

module ftsve_cfg (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [ftsve_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [ftsve_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [ftsve_pkg::APB_DATA_W-1:0]  prdata,
    output logic                              pready,
    output ftsve_pkg::ftsve_cfg_t             cfg
);
    import ftsve_pkg::*;

    ftsve_cfg_t cfg_reg;
    ftsve_cfg_t cfg_next;
    logic [1:0] reg_index;
    logic       wr_en;

    assign reg_index = paddr[APB_ADDR_W-1:2];
    assign wr_en     = psel && penable && pwrite;
    assign pready    = 1'b1;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (reg_index)
                REG_ENTRY_COUNT: cfg_next.entry_count      = pwdata[CNT_W-1:0];
                REG_VOTE_SHIFT:  cfg_next.vote_shift       = pwdata[SHIFT_W-1:0];
                REG_VOTE_WIDTH:  cfg_next.vote_width       = pwdata[WIDTH_W-1:0];
                REG_VOTE_ENABLE: cfg_next.vote_enable_bits = pwdata[ENABLE_W-1:0];
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_index)
            REG_ENTRY_COUNT: prdata = APB_DATA_W'(cfg_reg.entry_count);
            REG_VOTE_SHIFT:  prdata = APB_DATA_W'(cfg_reg.vote_shift);
            REG_VOTE_WIDTH:  prdata = APB_DATA_W'(cfg_reg.vote_width);
            REG_VOTE_ENABLE: prdata = APB_DATA_W'(cfg_reg.vote_enable_bits);
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.entry_count      <= RST_ENTRY_COUNT;
            cfg_reg.vote_shift       <= RST_VOTE_SHIFT;
            cfg_reg.vote_width       <= RST_VOTE_WIDTH;
            cfg_reg.vote_enable_bits <= RST_VOTE_ENABLE;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ----- hw/rtl/ftsve_ctrl.sv -----
// controller state machine: accepts words, sequences the table scan and the encode
// depends on ftsve_pkg for the state enum, command and status structs

module ftsve_ctrl #(
    parameter  int TABLE_DEPTH = ftsve_pkg::TABLE_DEPTH_DEF,
    localparam int AW          = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    input  logic                     in_command,
    output logic                     in_ready,
    input  logic [AW-1:0]            scan_last,
    input  ftsve_pkg::ftsve_status_t status,
    output ftsve_pkg::ftsve_cmd_t    cmd,
    output logic [AW-1:0]            rd_addr
);
    import ftsve_pkg::*;

    ftsve_state_t  state_reg;
    ftsve_state_t  state_next;
    logic [AW-1:0] scan_cnt_reg;
    logic [AW-1:0] scan_cnt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            scan_cnt_reg <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            scan_cnt_reg <= scan_cnt_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        scan_cnt_next = scan_cnt_reg;
        cmd           = '0;
        in_ready      = 1'b0;
        rd_addr       = scan_cnt_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (in_command == CMD_REQUEST)
                    begin
                        cmd.req_start = 1'b1;
                        scan_cnt_next = scan_last;
                        state_next    = ST_SCAN;
                    end
                    else
                    begin
                        cmd.load_en = 1'b1;
                    end
                end
            end
            ST_SCAN:
            begin
                // scan from the last slot in use down to slot 0
                cmd.rd_en    = 1'b1;
                cmd.rd_first = (scan_cnt_reg == scan_last);
                cmd.rd_last  = (scan_cnt_reg == '0);
                if (scan_cnt_reg == '0)
                begin
                    state_next = ST_DRAIN;
                end
                else
                begin
                    scan_cnt_next = scan_cnt_reg - AW'(1);
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_CHOOSE;
            end
            ST_CHOOSE:
            begin
                cmd.choose = 1'b1;
                state_next = ST_ENCODE;
            end
            ST_ENCODE:
            begin
                if (!status.out_busy)
                begin
                    cmd.encode = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ----- hw/rtl/ftsve_dp.sv -----
// datapath: frequency table memory, scan compare unit, vote encoder, output register
// depends on ftsve_pkg for widths, constants, config, command and status structs

module ftsve_dp #(
    parameter  int TABLE_DEPTH = ftsve_pkg::TABLE_DEPTH_DEF,
    localparam int AW          = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  ftsve_pkg::ftsve_cfg_t               cfg,
    input  ftsve_pkg::ftsve_cmd_t               cmd,
    input  logic [AW-1:0]                       rd_addr,
    output logic [AW-1:0]                       scan_last,
    output ftsve_pkg::ftsve_status_t            status,
    input  logic [ftsve_pkg::INDEX_W-1:0]       entry_index,
    input  logic [ftsve_pkg::FREQ_W-1:0]        entry_freq,
    input  logic [ftsve_pkg::FREQ_W-1:0]        request_freq,
    input  logic                                round_down,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [ftsve_pkg::FREQ_W-1:0]        chosen_freq,
    output logic                                vote_write,
    output logic [ftsve_pkg::FREQ_W-1:0]        vote_word
);
    import ftsve_pkg::*;

    localparam int CW = ($clog2(TABLE_DEPTH + 1) > CNT_W) ? $clog2(TABLE_DEPTH + 1) : CNT_W;
    localparam int LIM_W = FREQ_W + 1;

    logic [FREQ_W-1:0] mem [TABLE_DEPTH];

    // slot count clamp
    logic [CW-1:0]     count_ext;
    logic [CW-1:0]     used_cnt;
    logic [CW-1:0]     last_ext;
    logic [CW-1:0]     wr_index_ext;
    logic              wr_en;

    // read pipeline
    logic [FREQ_W-1:0] rd_data_reg;
    logic              rd_vld_reg;
    logic              rd_first_reg;
    logic              rd_last_reg;

    // request and scan accumulators
    logic [FREQ_W-1:0] req_reg;
    logic              down_reg;
    logic [FREQ_W-1:0] above_reg;
    logic [FREQ_W-1:0] above_next;
    logic [FREQ_W-1:0] le_max_reg;
    logic [FREQ_W-1:0] le_max_next;
    logic              le_vld_reg;
    logic              le_vld_next;
    logic [FREQ_W-1:0] f0_reg;
    logic [FREQ_W-1:0] f0_next;
    logic [FREQ_W-1:0] chosen_reg;
    logic [FREQ_W-1:0] below;
    logic              f_le;
    logic              f_ge;

    // encode
    logic [FREQ_W-1:0] cur_reg;
    logic              changed;
    logic [LIM_W-1:0]  vote_value;
    logic [LIM_W-1:0]  vote_limit;
    logic [LIM_W-1:0]  vote_sat;
    logic [LIM_W+14:0] vote_shifted;
    logic [FREQ_W-1:0] vote_full;

    // output register
    logic              out_valid_reg;
    logic [FREQ_W-1:0] out_chosen_reg;
    logic              out_write_reg;
    logic [FREQ_W-1:0] out_word_reg;

    // entry count of zero means one, above depth means depth
    always_comb
    begin
        count_ext = CW'(cfg.entry_count);
        if (count_ext == '0)
        begin
            used_cnt = CW'(1);
        end
        else if (count_ext > CW'(TABLE_DEPTH))
        begin
            used_cnt = CW'(TABLE_DEPTH);
        end
        else
        begin
            used_cnt = count_ext;
        end
        last_ext = used_cnt - CW'(1);
    end

    assign scan_last    = last_ext[AW-1:0];
    assign wr_index_ext = CW'(entry_index);
    assign wr_en        = cmd.load_en && (wr_index_ext < CW'(TABLE_DEPTH));

    // table memory, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_index_ext[AW-1:0]] <= entry_freq;
        end
        if (cmd.rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // compare unit, one table entry per cycle
    assign f_le = (rd_data_reg <= req_reg);
    assign f_ge = (rd_data_reg >= req_reg);

    always_comb
    begin
        above_next  = above_reg;
        le_max_next = le_max_reg;
        le_vld_next = le_vld_reg;
        f0_next     = f0_reg;
        if (rd_vld_reg)
        begin
            if (rd_first_reg)
            begin
                above_next  = rd_data_reg;
                le_max_next = rd_data_reg;
                le_vld_next = f_le;
            end
            else
            begin
                if (f_ge && (rd_data_reg < above_reg))
                begin
                    above_next = rd_data_reg;
                end
                if (f_le && (!le_vld_reg || (rd_data_reg > le_max_reg)))
                begin
                    le_max_next = rd_data_reg;
                    le_vld_next = 1'b1;
                end
            end
            if (rd_last_reg)
            begin
                f0_next = rd_data_reg;
            end
        end
    end

    // floor result never drops below slot 0
    assign below = (le_vld_reg && (le_max_reg > f0_reg)) ? le_max_reg : f0_reg;

    // vote encode: value saturated to the field width, shifted into place
    assign changed      = (chosen_reg != cur_reg);
    assign vote_value   = LIM_W'(chosen_reg >> VOTE_VALUE_SHIFT);
    assign vote_limit   = (LIM_W'(1) << cfg.vote_width) - LIM_W'(1);
    assign vote_sat     = (vote_value > vote_limit) ? vote_limit : vote_value;
    assign vote_shifted = (LIM_W+15)'(vote_sat) << cfg.vote_shift;
    assign vote_full    = vote_shifted[FREQ_W-1:0]
                        | (FREQ_W'(cfg.vote_enable_bits) << ENABLE_POS);

    always_ff @(posedge clk)
    begin
        if (cmd.req_start)
        begin
            req_reg  <= request_freq;
            down_reg <= round_down;
        end
        above_reg  <= above_next;
        le_max_reg <= le_max_next;
        f0_reg     <= f0_next;
        if (cmd.choose)
        begin
            chosen_reg <= down_reg ? below : above_reg;
        end
        if (cmd.encode)
        begin
            out_chosen_reg <= chosen_reg;
            out_write_reg  <= changed;
            out_word_reg   <= changed ? vote_full : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_vld_reg    <= 1'b0;
            rd_first_reg  <= 1'b0;
            rd_last_reg   <= 1'b0;
            le_vld_reg    <= 1'b0;
            cur_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            rd_vld_reg   <= cmd.rd_en;
            rd_first_reg <= cmd.rd_first;
            rd_last_reg  <= cmd.rd_last;
            le_vld_reg   <= le_vld_next;
            if (cmd.encode)
            begin
                cur_reg       <= chosen_reg;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign status.out_busy = out_valid_reg && !out_ready;
    assign out_valid       = out_valid_reg;
    assign chosen_freq     = out_chosen_reg;
    assign vote_write      = out_write_reg;
    assign vote_word       = out_word_reg;

endmodule

// ----- hw/rtl/ftsve_checker.sv -----
// port-level checker for the frequency table snap and vote encoder, with its bind
// depends on ftsve_pkg for widths and command codes

module ftsve_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_ready,
    input logic                          in_command,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic [ftsve_pkg::FREQ_W-1:0]  chosen_freq,
    input logic                          vote_write,
    input logic [ftsve_pkg::FREQ_W-1:0]  vote_word
);
    import ftsve_pkg::*;

    // a result word is held until taken
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result word dropped before it was taken");

    // a stalled result word keeps its contents
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(chosen_freq) && $stable(vote_write)
                                    && $stable(vote_word))
        else $error("stalled result word changed");

    // no vote issued means an empty vote word
    a_no_vote_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !vote_write |-> vote_word == '0)
        else $error("vote word not zero without a vote");

    // a request occupies the block for its scan
    a_req_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (in_command == CMD_REQUEST) |=> !in_ready)
        else $error("input ready right after a request was accepted");

endmodule

bind freq_table_snap_and_vote_encode ftsve_checker u_ftsve_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (items.valid),
    .in_ready    (items.ready),
    .in_command  (items.command),
    .out_valid   (results.valid),
    .out_ready   (results.ready),
    .chosen_freq (results.chosen_freq),
    .vote_write  (results.vote_write),
    .vote_word   (results.vote_word)
);
